/* src/hrrp_pkg.sv */
// Shared types and codes for the highest response ratio picker.
// No dependencies; imported by every module of the block.
package hrrp_pkg;

   localparam logic OP_ADD  = 1'b0;
   localparam logic OP_PICK = 1'b1;

   localparam logic [2:0] ST_GRANTED  = 3'd0;
   localparam logic [2:0] ST_ADDED    = 3'd1;
   localparam logic [2:0] ST_FULL     = 3'd2;
   localparam logic [2:0] ST_EMPTY    = 3'd3;
   localparam logic [2:0] ST_ZERO_RUN = 3'd4;

   localparam int NUM_W  = 34;
   localparam int PROD_W = 50;

   typedef struct packed {
      logic        valid;
      logic [7:0]  id;
      logic [31:0] arrival;
      logic [15:0] run;
   } slot_type;

   typedef struct packed {
      logic start;
      logic load_num;
      logic use_next;
      logic mult;
      logic cmp;
   } scan_ctrl_type;

endpackage

/* src/hrrp_cell.sv */
// One slot of the job ring: holds a job and passes it to its neighbor on shift.
// Depends on hrrp_pkg.
module hrrp_cell import hrrp_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     shift_en,
   input  slot_type shift_in,
   input  logic     wr_en,
   input  slot_type wr_data,
   input  logic     clr_en,
   output slot_type slot_out
);

   logic        valid_ff, valid_in;
   logic [7:0]  id_ff, id_in;
   logic [31:0] arrival_ff, arrival_in;
   logic [15:0] run_ff, run_in;

   always_comb begin
      valid_in   = valid_ff;
      id_in      = id_ff;
      arrival_in = arrival_ff;
      run_in     = run_ff;
      if (shift_en) begin
         valid_in   = shift_in.valid;
         id_in      = shift_in.id;
         arrival_in = shift_in.arrival;
         run_in     = shift_in.run;
      end else if (wr_en) begin
         valid_in   = wr_data.valid;
         id_in      = wr_data.id;
         arrival_in = wr_data.arrival;
         run_in     = wr_data.run;
      end else if (clr_en) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      id_ff      <= id_in;
      arrival_ff <= arrival_in;
      run_ff     <= run_in;
   end

   assign slot_out.valid   = valid_ff;
   assign slot_out.id      = id_ff;
   assign slot_out.arrival = arrival_ff;
   assign slot_out.run     = run_ff;

endmodule

/* src/hrrp_scan.sv */
// Shared cross-multiply comparator that tracks the best job while the ring rotates.
// Depends on hrrp_pkg.
module hrrp_scan import hrrp_pkg::*; #(
   parameter int MAX_JOBS = 16,
   parameter int IDX_W    = $clog2(MAX_JOBS)
) (
   input  logic                clock,
   input  logic                reset,
   input  scan_ctrl_type       ctrl,
   input  logic [31:0]         tick,
   input  slot_type            head,
   input  slot_type            next,
   input  logic [IDX_W-1:0]    pos,
   output logic                found,
   output logic [IDX_W-1:0]    best_idx,
   output logic [7:0]          best_id,
   output logic [15:0]         best_run
);

   logic [31:0]       tick_ff;
   logic [NUM_W-1:0]  num_ff, num_in;
   logic [PROD_W-1:0] prod_a_ff, prod_b_ff;
   logic [NUM_W-1:0]  best_num_ff;
   logic [15:0]       best_run_ff;
   logic [7:0]        best_id_ff;
   logic [IDX_W-1:0]  best_idx_ff;
   logic              found_ff;
   logic              take;
   slot_type          src;
   logic [31:0]       wait_val;

   always_comb begin
      src      = ctrl.use_next ? next : head;
      wait_val = (tick_ff >= src.arrival) ? (tick_ff - src.arrival) : 32'd0;
      num_in   = NUM_W'(wait_val) + NUM_W'(1) + NUM_W'(src.run);
      take     = head.valid && (!found_ff || (prod_a_ff > prod_b_ff));
   end

   always_ff @(posedge clock) begin
      if (ctrl.start) begin
         tick_ff <= tick;
      end
      if (ctrl.load_num) begin
         num_ff <= num_in;
      end
      if (ctrl.mult) begin
         prod_a_ff <= PROD_W'(num_ff * best_run_ff);
         prod_b_ff <= PROD_W'(best_num_ff * head.run);
      end
      if (ctrl.cmp && take) begin
         best_num_ff <= num_ff;
         best_run_ff <= head.run;
         best_id_ff  <= head.id;
         best_idx_ff <= pos;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else if (ctrl.start) begin
         found_ff <= 1'b0;
      end else if (ctrl.cmp && take) begin
         found_ff <= 1'b1;
      end
   end

   assign found    = found_ff;
   assign best_idx = best_idx_ff;
   assign best_id  = best_id_ff;
   assign best_run = best_run_ff;

endmodule

/* src/highest_response_ratio_picker.sv */
// Highest response ratio picker: top level with the job ring, controller and result register.
// Depends on hrrp_pkg, hrrp_cell and hrrp_scan.
//
// Usage: req_* carries one word per command. req_op selects add (job_id,
// arrival_time, run_time) or pick (tick). rsp_* returns exactly one word per
// command: status, granted_id and granted_run_time.
// An add completes in the accept cycle; its word appears on rsp_* in the next
// cycle. A pick rotates the job ring once through a single cross-multiply
// comparator: a prime state, then a multiply and a compare state per slot,
// then a done state that registers the word once the result register is free.
// The ring order is restored when the rotation ends, then the chosen slot is freed.
// One command is in flight at a time; req_ready is low during a pick.
// Reset empties the table and drops any waiting result word.
// When the receiver holds rsp_ready low, the result register holds its word
// and a further command is accepted only once that word is taken.
module highest_response_ratio_picker import hrrp_pkg::*; #(
   parameter int MAX_JOBS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_op,
   input  logic [31:0] req_tick,
   input  logic [7:0]  req_job_id,
   input  logic [31:0] req_arrival_time,
   input  logic [15:0] req_run_time,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [7:0]  rsp_granted_id,
   output logic [15:0] rsp_granted_run_time
);

   localparam int IDX_W = $clog2(MAX_JOBS);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_PRIME = 5'b00010,
      S_MULT  = 5'b00100,
      S_CMP   = 5'b01000,
      S_DONE  = 5'b10000
   } state_type;

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [2:0]       status_ff, status_in;
   logic [7:0]       gid_ff, gid_in;
   logic [15:0]      grun_ff, grun_in;

   slot_type         slots [MAX_JOBS];
   slot_type         wr_data;
   scan_ctrl_type    ctrl;
   logic             accept, out_free, shift_en, add_commit, done_commit;
   logic             free_found;
   logic [IDX_W-1:0] free_idx;
   logic             found;
   logic [IDX_W-1:0] best_idx;
   logic [7:0]       best_id;
   logic [15:0]      best_run;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && out_free;
   assign accept    = req_valid && req_ready;

   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = MAX_JOBS - 1; i >= 0; i--) begin
         if (!slots[i].valid) begin
            free_found = 1'b1;
            free_idx   = IDX_W'(i);
         end
      end
   end

   assign wr_data.valid   = 1'b1;
   assign wr_data.id      = req_job_id;
   assign wr_data.arrival = req_arrival_time;
   assign wr_data.run     = req_run_time;

   for (genvar g = 0; g < MAX_JOBS; g++) begin : g_ring
      hrrp_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift_en (shift_en),
         .shift_in (slots[(g + 1) % MAX_JOBS]),
         .wr_en    (add_commit && (free_idx == IDX_W'(g))),
         .wr_data  (wr_data),
         .clr_en   (done_commit && found && (best_idx == IDX_W'(g))),
         .slot_out (slots[g])
      );
   end

   hrrp_scan #(
      .MAX_JOBS (MAX_JOBS),
      .IDX_W    (IDX_W)
   ) u_scan (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (ctrl),
      .tick     (req_tick),
      .head     (slots[0]),
      .next     (slots[1]),
      .pos      (cnt_ff),
      .found    (found),
      .best_idx (best_idx),
      .best_id  (best_id),
      .best_run (best_run)
   );

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      status_in    = status_ff;
      gid_in       = gid_ff;
      grun_in      = grun_ff;
      ctrl         = '0;
      shift_en     = 1'b0;
      add_commit   = 1'b0;
      done_commit  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_op == OP_ADD) begin
                  rsp_valid_in = 1'b1;
                  gid_in       = 8'd0;
                  grun_in      = 16'd0;
                  if (req_run_time == 16'd0) begin
                     status_in = ST_ZERO_RUN;
                  end else if (!free_found) begin
                     status_in = ST_FULL;
                  end else begin
                     status_in  = ST_ADDED;
                     add_commit = 1'b1;
                  end
               end else begin
                  ctrl.start = 1'b1;
                  cnt_in     = '0;
                  state_in   = S_PRIME;
               end
            end
         end
         S_PRIME: begin
            ctrl.load_num = 1'b1;
            state_in      = S_MULT;
         end
         S_MULT: begin
            ctrl.mult = 1'b1;
            state_in  = S_CMP;
         end
         S_CMP: begin
            ctrl.cmp      = 1'b1;
            ctrl.load_num = 1'b1;
            ctrl.use_next = 1'b1;
            shift_en      = 1'b1;
            if (cnt_ff == IDX_W'(MAX_JOBS - 1)) begin
               state_in = S_DONE;
            end else begin
               cnt_in   = cnt_ff + IDX_W'(1);
               state_in = S_MULT;
            end
         end
         S_DONE: begin
            if (out_free) begin
               done_commit  = 1'b1;
               rsp_valid_in = 1'b1;
               if (found) begin
                  status_in = ST_GRANTED;
                  gid_in    = best_id;
                  grun_in   = best_run;
               end else begin
                  status_in = ST_EMPTY;
                  gid_in    = 8'd0;
                  grun_in   = 16'd0;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      gid_ff    <= gid_in;
      grun_ff   <= grun_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = status_ff;
   assign rsp_granted_id       = gid_ff;
   assign rsp_granted_run_time = grun_ff;

endmodule

/* bench/tb_highest_response_ratio_picker.sv */
`timescale 1ns / 100ps
// Self-checking bench for highest_response_ratio_picker: job adds and picks through a
// job-table scoreboard that recomputes every response word. Depends on hrrp_pkg and the RTL.
module tb_highest_response_ratio_picker;
   import hrrp_pkg::*;

   localparam int SLOTS       = 16;
   localparam int QUIET_LIMIT = 2000;
   localparam int RAND_ITEMS  = 750;

   typedef struct packed {
      logic [2:0]  status;
      logic [7:0]  id;
      logic [15:0] run_time;
   } answer_type;

   typedef enum int {RX_OPEN, RX_ALTERNATE, RX_RANDOM, RX_SLOW} rx_mode_type;

   class scoreboard_type;
      bit          occupied [SLOTS];
      logic [7:0]  job_id_of [SLOTS];
      logic [31:0] arrival_of [SLOTS];
      logic [15:0] run_of [SLOTS];
      answer_type  pending_answers [$];
      int          mismatches;

      function new();
         foreach (occupied[s]) occupied[s] = 1'b0;
         mismatches = 0;
      endfunction

      task report(string msg);
         mismatches++;
         if (mismatches <= 40) $display("ERROR at %0t: %s", $time, msg);
      endtask

      function void note_command(logic op, logic [31:0] tick, logic [7:0] id,
                                 logic [31:0] arrival, logic [15:0] run_time);
         answer_type  ans;
         int          best;
         logic [31:0] waited;
         logic [63:0] num, best_num, best_run;
         ans = '{status: ST_ADDED, id: 8'd0, run_time: 16'd0};
         if (op == OP_ADD) begin
            if (run_time == 16'd0) begin
               ans.status = ST_ZERO_RUN;
            end else begin
               ans.status = ST_FULL;
               for (int s = 0; s < SLOTS; s++) begin
                  if (!occupied[s]) begin
                     occupied[s]   = 1'b1;
                     job_id_of[s]  = id;
                     arrival_of[s] = arrival;
                     run_of[s]     = run_time;
                     ans.status    = ST_ADDED;
                     break;
                  end
               end
            end
         end else begin
            best     = -1;
            best_num = 64'd0;
            best_run = 64'd1;
            for (int s = 0; s < SLOTS; s++) begin
               if (occupied[s]) begin
                  // saturate a negative wait to zero
                  waited = (tick >= arrival_of[s]) ? tick - arrival_of[s] : 32'd0;
                  num = {32'd0, waited} + 64'd1 + {48'd0, run_of[s]};
                  if (best < 0 || num * best_run > best_num * {48'd0, run_of[s]}) begin
                     best     = s;
                     best_num = num;
                     best_run = {48'd0, run_of[s]};
                  end
               end
            end
            if (best < 0) begin
               ans.status = ST_EMPTY;
            end else begin
               ans.status   = ST_GRANTED;
               ans.id       = job_id_of[best];
               ans.run_time = run_of[best];
               occupied[best] = 1'b0;
            end
         end
         pending_answers.push_back(ans);
      endfunction

      task check_result(logic [2:0] status, logic [7:0] id, logic [15:0] run_time);
         answer_type want;
         if (pending_answers.size() == 0) begin
            report($sformatf("unexpected word: status %0d id %0d run %0d",
                             status, id, run_time));
            return;
         end
         want = pending_answers.pop_front();
         if (status !== want.status)
            report($sformatf("status %0d, want %0d", status, want.status));
         if (id !== want.id)
            report($sformatf("granted_id %0d, want %0d", id, want.id));
         if (run_time !== want.run_time)
            report($sformatf("granted_run_time %0d, want %0d", run_time, want.run_time));
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_op = OP_ADD;
   logic [31:0] req_tick = 32'd0;
   logic [7:0]  req_job_id = 8'd0;
   logic [31:0] req_arrival_time = 32'd0;
   logic [15:0] req_run_time = 16'd0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_status;
   logic [7:0]  rsp_granted_id;
   logic [15:0] rsp_granted_run_time;

   scoreboard_type   sb = new();
   int               quiet_cycles = 0;
   int               rx_cycle = 0;
   rx_mode_type      rx_mode = RX_OPEN;

   highest_response_ratio_picker #(.MAX_JOBS(SLOTS)) uut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_op               (req_op),
      .req_tick             (req_tick),
      .req_job_id           (req_job_id),
      .req_arrival_time     (req_arrival_time),
      .req_run_time         (req_run_time),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_status           (rsp_status),
      .rsp_granted_id       (rsp_granted_id),
      .rsp_granted_run_time (rsp_granted_run_time)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready)
            sb.check_result(rsp_status, rsp_granted_id, rsp_granted_run_time);
         if (req_valid && req_ready)
            sb.note_command(req_op, req_tick, req_job_id, req_arrival_time, req_run_time);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   always @(negedge clock) begin
      rx_cycle <= rx_cycle + 1;
      if (rx_cycle % 80 == 0) rx_mode <= rx_mode_type'($urandom_range(0, 3));
      case (rx_mode)
         RX_OPEN:      rsp_ready <= 1'b1;
         RX_ALTERNATE: rsp_ready <= rx_cycle[0];
         RX_RANDOM:    rsp_ready <= ($urandom_range(0, 3) != 0);
         default:      rsp_ready <= (rx_cycle % 9 == 0);
      endcase
   end

   task automatic send_command(logic op, logic [31:0] tick, logic [7:0] id,
                               logic [31:0] arrival, logic [15:0] run_time);
      @(negedge clock);
      req_valid        <= 1'b1;
      req_op           <= op;
      req_tick         <= tick;
      req_job_id       <= id;
      req_arrival_time <= arrival;
      req_run_time     <= run_time;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic hold_off(int cycles);
      @(negedge clock);
      req_valid <= 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   task automatic wait_for_answers();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending_answers.size() != 0) @(posedge clock);
   endtask

   initial begin
      int          add_pct;
      int          burst_left;
      int          pick;
      logic        op;
      logic [31:0] time_base, tick, arrival;
      logic [7:0]  id;
      logic [15:0] run_time;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty table, zero run time, then fill to the brim
      send_command(OP_PICK, 32'd0, 8'd0, 32'd0, 16'd0);
      send_command(OP_ADD, 32'hFFFF_FFFF, 8'hFF, 32'd5, 16'd0);
      send_command(OP_ADD, 32'd0, 8'h00, 32'h0000_0000, 16'hFFFF);
      send_command(OP_ADD, 32'd0, 8'hFF, 32'hFFFF_FFFF, 16'd1);
      send_command(OP_ADD, 32'd0, 8'h5A, 32'd100, 16'd10);
      send_command(OP_ADD, 32'd0, 8'hA5, 32'd100, 16'd10);
      for (int k = 4; k < SLOTS; k++)
         send_command(OP_ADD, $urandom, 8'h10 + k[7:0], 32'd1000 + 7 * k, 16'd1000 + k[15:0]);
      send_command(OP_ADD, 32'd0, 8'h77, 32'd50, 16'd5);
      send_command(OP_ADD, 32'd0, 8'h78, 32'd50, 16'd0);
      // huge wait, negative wait, tie between identical jobs
      send_command(OP_PICK, 32'hFFFF_FFFF, 8'd0, 32'd0, 16'd0);
      send_command(OP_PICK, 32'd0, 8'd0, 32'd0, 16'd0);
      send_command(OP_PICK, 32'd105, 8'd0, 32'd0, 16'd0);
      send_command(OP_PICK, 32'd105, 8'd0, 32'd0, 16'd0);
      send_command(OP_PICK, 32'h8000_0000, 8'd0, 32'd0, 16'd0);
      wait_for_answers();

      time_base  = $urandom;
      add_pct    = 50;
      burst_left = 0;
      for (int n = 0; n < RAND_ITEMS; n++) begin
         if (n % 60 == 0) begin
            case ($urandom_range(0, 2))
               0:       add_pct = 80;
               1:       add_pct = 50;
               default: add_pct = 25;
            endcase
         end
         if (n % 150 == 149) wait_for_answers();
         if (burst_left == 0) begin
            if ($urandom_range(0, 3) != 0) hold_off($urandom_range(1, 12));
            burst_left = $urandom_range(1, 16);
         end
         burst_left--;
         time_base = time_base + $urandom_range(0, 40);
         op = ($urandom_range(0, 99) < add_pct) ? OP_ADD : OP_PICK;
         id = $urandom_range(0, 255);

         pick = $urandom_range(0, 19);
         if (pick == 0)      run_time = 16'd0;
         else if (pick < 9)  run_time = $urandom_range(1, 20);
         else if (pick < 15) run_time = $urandom_range(1, 1000);
         else                run_time = $urandom_range(1, 65535);

         pick = $urandom_range(0, 9);
         if (pick < 7)       arrival = time_base - $urandom_range(0, 300);
         else if (pick == 7) arrival = time_base + $urandom_range(1, 100);
         else                arrival = $urandom;

         pick = $urandom_range(0, 9);
         if (pick < 8)       tick = time_base + $urandom_range(0, 60);
         else if (pick == 8) tick = $urandom;
         else                tick = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;

         send_command(op, tick, id, arrival, run_time);
      end
      wait_for_answers();
      repeat (40) @(posedge clock);

      if (sb.pending_answers.size() != 0)
         sb.report($sformatf("%0d response words never arrived", sb.pending_answers.size()));
      if (sb.mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
